### src/rgb_hsl_converter_core_macros.svh
// Assertion macros used by the converter core.
// Needs nothing but a clock and a synchronous active-low reset in scope.
`ifndef RGB_HSL_CONVERTER_CORE_MACROS_SVH
`define RGB_HSL_CONVERTER_CORE_MACROS_SVH

// Implication checked every rising clock edge outside reset.
`define RHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rhc_pkg.sv
// Package for the RGB/HSL converter: widths, opcodes and the stage payload type.
// Depends on nothing.
`timescale 1ns / 1ps
package rhc_pkg;
    localparam int CH_BITS  = 8;
    localparam int HUE_BITS = 16;
    localparam int CH_MAX   = (1 << CH_BITS) - 1;
    // Divider widths: a numerator below 6*C*2^HUE_BITS, a quotient of HUE_BITS+1 bits.
    localparam int Q_BITS   = HUE_BITS + 1;
    localparam int D_BITS   = CH_BITS + 3;
    localparam int N_BITS   = D_BITS + Q_BITS;
    localparam int N_CELLS  = Q_BITS;

    typedef enum logic {
        t_OP_RGB2HSL = 1'b0,
        t_OP_HSL2RGB = 1'b1
    } t_op;

    typedef struct packed {
        logic [CH_BITS-1:0]  red;
        logic [CH_BITS-1:0]  green;
        logic [CH_BITS-1:0]  blue;
        logic [HUE_BITS-1:0] hue;
        logic [CH_BITS-1:0]  sat;
        logic [CH_BITS-1:0]  light;
    } t_pix;

    // Two long divisions run side by side in the cell chain: hue and saturation.
    typedef struct packed {
        logic                 op;
        logic                 neg;      // hue wraps negative (red dominant, green below blue)
        logic                 zero_c;
        logic [N_BITS-1:0]    h_rem;    // remainder, taking in numerator bits at the bottom
        logic [Q_BITS-1:0]    h_num;    // numerator bits still to be shifted in
        logic [Q_BITS-1:0]    h_quo;
        logic [D_BITS-1:0]    h_den;
        logic [D_BITS-1:0]    s_rem;
        logic [Q_BITS-1:0]    s_num;
        logic [Q_BITS-1:0]    s_quo;
        logic [D_BITS-1:0]    s_den;
        t_pix                 pix;
    } t_cell;
endpackage

### src/rhc_if.sv
// Valid/ready stream interface carrying one pixel item.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
interface rhc_if;
    import rhc_pkg::*;
    logic  valid;
    logic  ready;
    logic  opcode;
    t_pix  data;
    modport source (output valid, output opcode, output data, input ready);
    modport sink   (input valid, input opcode, input data, output ready);
endinterface

### src/rgb_hsl_converter_core.sv
// RGB/HSL converter. The pipeline has 17 division cells, a front stage pair and an
// output stage; one item is accepted every cycle while the output is not stalled.
// Each cell of the division chain yields one quotient bit of each divider.
// The whole pipeline advances together; it stalls only when the output stage is
// full and not being taken. Synchronous active-low reset clears all valid flags.
`timescale 1ns / 1ps
`include "rgb_hsl_converter_core_macros.svh"
module rgb_hsl_converter_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rhc_if.sink   i_pix,
    rhc_if.source o_pix
);
    import rhc_pkg::*;

    // The pipeline moves whenever the output register is free or being emptied,
    // so the input may be taken while a finished item is being taken downstream.
    logic en;
    logic          v_chain [N_CELLS+1];
    t_cell         c_chain [N_CELLS+1];
    t_pix          n_out;
    logic          r_out_v;
    logic          r_out_op;
    t_pix          r_out;
    logic [HUE_BITS-1:0] hq;

    assign en          = !r_out_v || o_pix.ready;
    assign i_pix.ready = en;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pix.valid),
        .i_op    (i_pix.opcode),
        .i_pix   (i_pix.data),
        .o_valid (v_chain[0]),
        .o_cell  (c_chain[0])
    );

    // Row of division cells, each handing its partial remainder to the next.
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        rhc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[k]),
            .i_cell  (c_chain[k]),
            .o_valid (v_chain[k+1]),
            .o_cell  (c_chain[k+1])
        );
    end

    // Result selection. The negative-hue case wraps to H minus the quotient.
    always_comb begin
        n_out = c_chain[N_CELLS].pix;
        hq    = c_chain[N_CELLS].h_quo[HUE_BITS-1:0];
        if (c_chain[N_CELLS].op == t_OP_RGB2HSL) begin
            if (c_chain[N_CELLS].zero_c) begin
                n_out.hue = '0;
                n_out.sat = '0;
            end else begin
                n_out.hue = c_chain[N_CELLS].neg ? HUE_BITS'(0) - hq : hq;
                n_out.sat = (c_chain[N_CELLS].s_den == '0) ? CH_BITS'(0)
                          : c_chain[N_CELLS].s_quo[CH_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= v_chain[N_CELLS];
        end
        if (en) begin
            r_out    <= n_out;
            r_out_op <= c_chain[N_CELLS].op;
        end
    end

    assign o_pix.valid  = r_out_v;
    assign o_pix.data   = r_out;
    assign o_pix.opcode = r_out_op;

    `RHC_ASSERT_IMP(a_stall_hold, i_clk, i_rst_n, r_out_v && !o_pix.ready, !i_pix.ready, "input taken while output stalled")
    `RHC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_v && !o_pix.ready, r_out_v && $stable(r_out), "stalled result changed")
    `RHC_ASSERT_IMP(a_sat_zero, i_clk, i_rst_n, v_chain[N_CELLS] && c_chain[N_CELLS].zero_c && c_chain[N_CELLS].op == t_OP_RGB2HSL, n_out.sat == '0, "saturation not zero at zero chroma")
endmodule

### src/rhc_front.sv
// Front stage: extremes, chroma and divider set-up for RGB to HSL, and the full
// HSL to RGB datapath (multiplies registered inside). Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_op,
    input  rhc_pkg::t_pix  i_pix,
    output logic           o_valid,
    output rhc_pkg::t_cell o_cell
);
    import rhc_pkg::*;

    // Stage A registers.
    logic          r_va;
    logic          r_opa;
    t_pix          r_pixa;
    logic [2*CH_BITS-1:0] r_ds;     // d*s for HSL to RGB
    logic [2:0]    r_sector;
    logic [HUE_BITS:0] r_f;

    logic [CH_BITS-1:0] hi, lo, c;
    logic [CH_BITS:0]   sum, den;
    logic [CH_BITS:0]   twol, d;
    logic [2*CH_BITS+1:0] ds_full;
    logic [HUE_BITS+2:0]  six_h;
    logic [HUE_BITS:0]    t;
    t_cell n_cell;
    logic [D_BITS-1:0] gm;
    logic [D_BITS-1:0] hnum_hi;

    // HSL to RGB tail, second step.
    logic [CH_BITS-1:0] vc, vz, vx;
    logic [2*CH_BITS:0]   vzn;
    logic [2*CH_BITS+1:0] vxn;
    logic [2*CH_BITS+HUE_BITS:0] ds_f;

    // Floor division by M = 2^CH_BITS - 1, exact while the quotient stays below 2^CH_BITS.
    function automatic logic [CH_BITS-1:0] div_m(input logic [2*CH_BITS-1:0] y);
        logic [2*CH_BITS:0] acc;
        acc = (2*CH_BITS+1)'(y) + (2*CH_BITS+1)'(1) + (2*CH_BITS+1)'(y >> CH_BITS);
        return acc[2*CH_BITS-1:CH_BITS];
    endfunction

    always_comb begin
        twol = {i_pix.light, 1'b0};
        d    = (twol <= (CH_BITS+1)'(CH_MAX)) ? twol : (CH_BITS+1)'(2 * CH_MAX) - twol;
        ds_full = (2*CH_BITS+2)'(d) * (2*CH_BITS+2)'(i_pix.sat);
        six_h = (HUE_BITS+3)'(i_pix.hue) * (HUE_BITS+3)'(6);
        t     = six_h[HUE_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
        if (i_en) begin
            r_opa    <= i_op;
            r_pixa   <= i_pix;
            r_ds     <= ds_full[2*CH_BITS-1:0];
            r_sector <= six_h[HUE_BITS+2:HUE_BITS];
            r_f      <= t[HUE_BITS] ? (HUE_BITS+1)'(1 << (HUE_BITS+1)) - t : t;
        end
    end

    // Constant 2M: vc = l + floor(ds / 2M), vz = floor((2M*l - ds) / 2M).
    // vx = floor((2M*l - ds + floor(2*ds*f / H)) / 2M); each /2M is a halving and a /M.
    always_comb begin
        vc   = r_pixa.light + div_m(r_ds >> 1);
        vzn  = (2*CH_BITS+1)'(2 * CH_MAX) * (2*CH_BITS+1)'(r_pixa.light)
               - (2*CH_BITS+1)'(r_ds);
        vz   = div_m(vzn[2*CH_BITS:1]);
        ds_f = (2*CH_BITS+HUE_BITS+1)'(r_ds) * (2*CH_BITS+HUE_BITS+1)'(r_f);
        vxn  = (2*CH_BITS+2)'(vzn) + (2*CH_BITS+2)'(ds_f >> (HUE_BITS - 1));
        vx   = div_m(vxn[2*CH_BITS:1]);
    end

    // RGB to HSL set-up on the stage A pixel, and the HSL to RGB channel placement.
    always_comb begin
        hi = r_pixa.red;
        lo = r_pixa.red;
        if (r_pixa.green > hi) hi = r_pixa.green;
        if (r_pixa.blue  > hi) hi = r_pixa.blue;
        if (r_pixa.green < lo) lo = r_pixa.green;
        if (r_pixa.blue  < lo) lo = r_pixa.blue;
        c   = hi - lo;
        sum = (CH_BITS+1)'(hi) + (CH_BITS+1)'(lo);
        den = (sum <= (CH_BITS+1)'(CH_MAX)) ? sum : (CH_BITS+1)'(2 * CH_MAX) - sum;
        n_cell = '0;
        n_cell.op     = r_opa;
        n_cell.pix    = r_pixa;
        n_cell.zero_c = (c == '0);
        n_cell.h_den  = D_BITS'(c) * D_BITS'(6);
        n_cell.s_den  = D_BITS'(den);
        gm = '0;
        if (r_pixa.red >= r_pixa.green && r_pixa.red >= r_pixa.blue) begin
            if (r_pixa.green >= r_pixa.blue) begin
                gm = D_BITS'(r_pixa.green - r_pixa.blue);
            end else begin
                // ceil((b-g)H / 6c) = floor(((b-g)H + 6c - 1) / 6c)
                gm = D_BITS'(r_pixa.blue - r_pixa.green);
                n_cell.neg = 1'b1;
            end
        end else if (r_pixa.green >= r_pixa.blue) begin
            gm = D_BITS'(r_pixa.blue) + D_BITS'({c, 1'b0}) - D_BITS'(r_pixa.red);
        end else begin
            gm = D_BITS'(r_pixa.red) + D_BITS'({c, 2'b00}) - D_BITS'(r_pixa.green);
        end
        // Numerator gm*H (+ 6c-1 when negative). Top bits start the remainder, low bits
        // (HUE_BITS+1 of them, led by the lowest bit of gm) are shifted in by the cells.
        hnum_hi = gm;
        n_cell.h_rem = '0;
        n_cell.h_num = Q_BITS'(0);
        if (n_cell.neg) begin
            // Add 6c-1 below the H scale: fits in the low HUE_BITS since 6c-1 < H.
            n_cell.h_num = Q_BITS'(n_cell.h_den - D_BITS'(1));
        end
        // Pre-load: remainder = gm >> 1, first shifted bit is gm[0].
        n_cell.h_rem = N_BITS'(hnum_hi >> 1);
        n_cell.h_num = {hnum_hi[0], n_cell.h_num[HUE_BITS-1:0]};
        // Saturation: c*M / den, with the numerator c*M = c*2^CH - c.
        n_cell.s_rem = '0;
        n_cell.s_num = Q_BITS'(0);
        if (r_opa == t_OP_RGB2HSL) begin
            n_cell.pix.light = sum[CH_BITS:1];
        end else begin
            n_cell.pix.red   = vc;
            n_cell.pix.green = vx;
            n_cell.pix.blue  = vz;
            case (r_sector)
                3'd0: begin n_cell.pix.red = vc; n_cell.pix.green = vx; n_cell.pix.blue = vz; end
                3'd1: begin n_cell.pix.red = vx; n_cell.pix.green = vc; n_cell.pix.blue = vz; end
                3'd2: begin n_cell.pix.red = vz; n_cell.pix.green = vc; n_cell.pix.blue = vx; end
                3'd3: begin n_cell.pix.red = vz; n_cell.pix.green = vx; n_cell.pix.blue = vc; end
                3'd4: begin n_cell.pix.red = vx; n_cell.pix.green = vz; n_cell.pix.blue = vc; end
                default: begin
                    n_cell.pix.red = vc; n_cell.pix.green = vz; n_cell.pix.blue = vx;
                end
            endcase
        end
        // The s numerator c*M sits below the top bit, so the remainder starts at zero.
        n_cell.s_rem = '0;
        n_cell.s_num = Q_BITS'((CH_BITS+CH_BITS)'(c) * (CH_BITS+CH_BITS)'(CH_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_va;
        end
        if (i_en) begin
            o_cell <= n_cell;
        end
    end
endmodule

### src/rhc_cell.sv
// One restoring-division cell: one quotient bit of the hue and saturation dividers.
// Depends on rhc_pkg.
`timescale 1ns / 1ps
module rhc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rhc_pkg::t_cell i_cell,
    output logic           o_valid,
    output rhc_pkg::t_cell o_cell
);
    import rhc_pkg::*;

    t_cell n_cell;
    logic [N_BITS-1:0] h_try;
    logic [D_BITS:0]   s_try;

    always_comb begin
        n_cell = i_cell;
        h_try  = {i_cell.h_rem[N_BITS-2:0], i_cell.h_num[Q_BITS-1]};
        n_cell.h_num = {i_cell.h_num[Q_BITS-2:0], 1'b0};
        if (h_try >= N_BITS'(i_cell.h_den)) begin
            n_cell.h_rem = h_try - N_BITS'(i_cell.h_den);
            n_cell.h_quo = {i_cell.h_quo[Q_BITS-2:0], 1'b1};
        end else begin
            n_cell.h_rem = h_try;
            n_cell.h_quo = {i_cell.h_quo[Q_BITS-2:0], 1'b0};
        end
        s_try = {i_cell.s_rem, i_cell.s_num[Q_BITS-1]};
        n_cell.s_num = {i_cell.s_num[Q_BITS-2:0], 1'b0};
        if (s_try >= (D_BITS+1)'(i_cell.s_den)) begin
            n_cell.s_rem = D_BITS'(s_try - (D_BITS+1)'(i_cell.s_den));
            n_cell.s_quo = {i_cell.s_quo[Q_BITS-2:0], 1'b1};
        end else begin
            n_cell.s_rem = D_BITS'(s_try);
            n_cell.s_quo = {i_cell.s_quo[Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_cell <= n_cell;
        end
    end
endmodule
